// ----- sv/dce_pkg.sv -----
// Package for the dilated 1-D convolution engine.
// Holds field widths, opcode and register index codes, fixed-point constants and the MAC control type.
// No dependencies.
package dce_pkg;

	localparam int OP_W       = 2;
	localparam int CH_W       = 6;
	localparam int TAP_W      = 4;
	localparam int TIME_W     = 10;
	localparam int DATA_W     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;

	localparam int NCH_W  = 7;
	localparam int LEN_W  = 11;
	localparam int NTAP_W = 5;
	localparam int DIL_W  = 7;
	localparam int PAD_W  = 10;

	localparam int OFF_W  = 14;
	localparam int POS_W  = 16;

	localparam int FRAC_W = 12;
	localparam int PROD_W = 2 * DATA_W;
	localparam int ACC_W  = 48;
	localparam int RND_W  = ACC_W + 1 - FRAC_W;

	localparam logic [OP_W-1:0] OP_WEIGHT  = 2'd0;
	localparam logic [OP_W-1:0] OP_BIAS    = 2'd1;
	localparam logic [OP_W-1:0] OP_SAMPLE  = 2'd2;
	localparam logic [OP_W-1:0] OP_COMPUTE = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_IN_CHANNELS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SEQ_LENGTH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_TAPS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DILATION    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PADDING     = 3'd4;

	localparam logic signed [RND_W-1:0] SAT_HI = RND_W'((64'sd1 <<< (DATA_W - 1)) - 64'sd1);
	localparam logic signed [RND_W-1:0] SAT_LO = -SAT_HI - RND_W'(1);
	localparam logic signed [ACC_W:0]   RND_HALF = (ACC_W + 1)'(64'sd1 <<< (FRAC_W - 1));

	typedef struct packed {
		logic load;
		logic mul_valid;
		logic mul_en;
	} mac_ctl_t;

endpackage

// ----- sv/dce_mac.sv -----
// Multiply-accumulate unit of the convolution engine: product stage, 48-bit wrapping accumulator,
// round-to-nearest and saturation of the sum. Depends on dce_pkg.
module dce_mac (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  dce_pkg::mac_ctl_t                    ctl,
	input  logic signed [dce_pkg::DATA_W-1:0]    bias,
	input  logic signed [dce_pkg::DATA_W-1:0]    weight,
	input  logic signed [dce_pkg::DATA_W-1:0]    sample,
	output logic                                 busy,
	output logic signed [dce_pkg::DATA_W-1:0]    result_value,
	output logic                                 saturated
);

	logic                                 v_s2;
	logic signed [dce_pkg::PROD_W-1:0]    prod;
	logic signed [dce_pkg::PROD_W-1:0]    prod_s2;
	logic signed [dce_pkg::ACC_W-1:0]     acc_q;
	logic signed [dce_pkg::ACC_W:0]       biased;
	logic signed [dce_pkg::RND_W-1:0]     rnd;

	assign prod = weight * sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= ctl.mul_valid;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= ctl.mul_en ? prod : '0;
		if (ctl.load) begin
			acc_q <= {{(dce_pkg::ACC_W - dce_pkg::DATA_W - dce_pkg::FRAC_W){bias[dce_pkg::DATA_W-1]}},
				bias, {dce_pkg::FRAC_W{1'b0}}};
		end else if (v_s2) begin
			acc_q <= acc_q + {{(dce_pkg::ACC_W - dce_pkg::PROD_W){prod_s2[dce_pkg::PROD_W-1]}},
				prod_s2};
		end
	end

	always_comb begin
		biased = {acc_q[dce_pkg::ACC_W-1], acc_q} + dce_pkg::RND_HALF;
		rnd    = biased[dce_pkg::ACC_W:dce_pkg::FRAC_W];
		if (rnd > dce_pkg::SAT_HI) begin
			result_value = dce_pkg::DATA_W'(dce_pkg::SAT_HI);
			saturated    = 1'b1;
		end else if (rnd < dce_pkg::SAT_LO) begin
			result_value = dce_pkg::DATA_W'(dce_pkg::SAT_LO);
			saturated    = 1'b1;
		end else begin
			result_value = rnd[dce_pkg::DATA_W-1:0];
			saturated    = 1'b0;
		end
	end

	assign busy = v_s2;

endmodule

// ----- sv/dilated_conv1d_engine_top.sv -----
// Top level of the dilated 1-D convolution engine: weight, bias and sample memories, the compute
// sequencer, output register and configuration registers. Depends on dce_pkg and dce_mac.

// Weight, bias and sample writes are accepted back to back. A compute item steps through
// in_channels * kernel_taps taps (none when either count is zero) on the single shared
// multiply-accumulate, which takes one tap per cycle read from simple dual-port weight and
// sample memories. The block accepts a new item as soon as the result of the previous one
// sits in the output register. Memories are not cleared: reading an entry never written gives
// undefined data.
module dilated_conv1d_engine_top #(
	parameter int MAX_IN_CH  = 64,
	parameter int MAX_OUT_CH = 64,
	parameter int MAX_LEN    = 1024,
	parameter int MAX_TAPS   = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [dce_pkg::OP_W-1:0]             opcode,
	input  logic [dce_pkg::CH_W-1:0]             out_channel,
	input  logic [dce_pkg::CH_W-1:0]             in_channel,
	input  logic [dce_pkg::TAP_W-1:0]            tap_index,
	input  logic [dce_pkg::TIME_W-1:0]           time_index,
	input  logic signed [dce_pkg::DATA_W-1:0]    data_value,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [dce_pkg::CH_W-1:0]             result_channel,
	output logic [dce_pkg::TIME_W-1:0]           result_time,
	output logic signed [dce_pkg::DATA_W-1:0]    result_value,
	output logic                                 saturated,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [dce_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [dce_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam int OCW = (MAX_OUT_CH > 1) ? $clog2(MAX_OUT_CH) : 1;
	localparam int ICW = (MAX_IN_CH > 1) ? $clog2(MAX_IN_CH) : 1;
	localparam int TW  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int LW  = $clog2(MAX_LEN);
	localparam int WAW = OCW + ICW + TW;
	localparam int SAW = ICW + LW;

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN} state_t;

	state_t                               state_q;
	logic [dce_pkg::NCH_W-1:0]            in_channels_q;
	logic [dce_pkg::LEN_W-1:0]            seq_length_q;
	logic [dce_pkg::NTAP_W-1:0]           kernel_taps_q;
	logic [dce_pkg::DIL_W-1:0]            dilation_q;
	logic [dce_pkg::PAD_W-1:0]            padding_q;

	logic [dce_pkg::NCH_W-1:0]            nch;
	logic [dce_pkg::LEN_W-1:0]            len;
	logic [dce_pkg::NTAP_W-1:0]           ntap;

	logic                                 in_accept;
	logic                                 w_we, b_we, s_we;
	logic [WAW-1:0]                       w_wa, w_ra;
	logic [SAW-1:0]                       s_wa, s_ra;

	logic signed [dce_pkg::DATA_W-1:0]    w_mem [2**WAW];
	logic signed [dce_pkg::DATA_W-1:0]    s_mem [2**SAW];
	logic signed [dce_pkg::DATA_W-1:0]    b_mem [2**OCW];
	logic signed [dce_pkg::DATA_W-1:0]    w_rd_s1, s_rd_s1, b_rd_q;

	logic [dce_pkg::CH_W-1:0]             oc_q;
	logic [dce_pkg::TIME_W-1:0]           t_q;
	logic                                 absent_q;
	logic [dce_pkg::NCH_W-1:0]            ic_cnt_q;
	logic [dce_pkg::NTAP_W-1:0]           tap_cnt_q;
	logic [dce_pkg::OFF_W-1:0]            off_q;
	logic                                 bias_load_q;
	logic                                 v_s1_q;
	logic                                 inrange_s1_q;
	logic signed [dce_pkg::POS_W-1:0]     pos;
	logic                                 pos_ok;
	logic                                 res_load;

	logic                                 out_valid_q;
	logic [dce_pkg::CH_W-1:0]             result_channel_q;
	logic [dce_pkg::TIME_W-1:0]           result_time_q;
	logic signed [dce_pkg::DATA_W-1:0]    result_value_q;
	logic                                 saturated_q;

	dce_pkg::mac_ctl_t                    mac_ctl;
	logic                                 mac_busy;
	logic signed [dce_pkg::DATA_W-1:0]    mac_bias;
	logic signed [dce_pkg::DATA_W-1:0]    mac_value;
	logic                                 mac_sat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_channels_q <= dce_pkg::NCH_W'(1);
			seq_length_q  <= dce_pkg::LEN_W'(1024);
			kernel_taps_q <= dce_pkg::NTAP_W'(3);
			dilation_q    <= dce_pkg::DIL_W'(1);
			padding_q     <= dce_pkg::PAD_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				dce_pkg::CFG_IN_CHANNELS: in_channels_q <= cfg_data[dce_pkg::NCH_W-1:0];
				dce_pkg::CFG_SEQ_LENGTH:  seq_length_q  <= cfg_data[dce_pkg::LEN_W-1:0];
				dce_pkg::CFG_KERNEL_TAPS: kernel_taps_q <= cfg_data[dce_pkg::NTAP_W-1:0];
				dce_pkg::CFG_DILATION:    dilation_q    <= cfg_data[dce_pkg::DIL_W-1:0];
				dce_pkg::CFG_PADDING:     padding_q     <= cfg_data[dce_pkg::PAD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		nch  = (int'(in_channels_q) > MAX_IN_CH) ? dce_pkg::NCH_W'(MAX_IN_CH) : in_channels_q;
		len  = (int'(seq_length_q) > MAX_LEN) ? dce_pkg::LEN_W'(MAX_LEN) : seq_length_q;
		ntap = (int'(kernel_taps_q) > MAX_TAPS) ? dce_pkg::NTAP_W'(MAX_TAPS) : kernel_taps_q;
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;

	assign w_we = in_accept && (opcode == dce_pkg::OP_WEIGHT) && (int'(out_channel) < MAX_OUT_CH)
		&& (int'(in_channel) < MAX_IN_CH) && (int'(tap_index) < MAX_TAPS);
	assign b_we = in_accept && (opcode == dce_pkg::OP_BIAS) && (int'(out_channel) < MAX_OUT_CH);
	assign s_we = in_accept && (opcode == dce_pkg::OP_SAMPLE) && (int'(in_channel) < MAX_IN_CH)
		&& (int'(time_index) < MAX_LEN);

	assign w_wa = {OCW'(out_channel), ICW'(in_channel), TW'(tap_index)};
	assign s_wa = {ICW'(in_channel), LW'(time_index)};

	always_comb begin
		pos    = dce_pkg::POS_W'(t_q) + dce_pkg::POS_W'(off_q) - dce_pkg::POS_W'(padding_q);
		pos_ok = !pos[dce_pkg::POS_W-1] && (unsigned'(pos) < dce_pkg::POS_W'(len));
		w_ra   = {OCW'(oc_q), ICW'(ic_cnt_q), TW'(tap_cnt_q)};
		s_ra   = {ICW'(ic_cnt_q), LW'(unsigned'(pos))};
	end

	assign res_load = (state_q == ST_DRAIN) && !v_s1_q && !mac_busy && !bias_load_q
		&& (!out_valid_q || !out_stall);

	always_ff @(posedge clk) begin
		if (w_we) begin
			w_mem[w_wa] <= data_value;
		end
		w_rd_s1 <= w_mem[w_ra];
	end

	always_ff @(posedge clk) begin
		if (s_we) begin
			s_mem[s_wa] <= data_value;
		end
		s_rd_s1 <= s_mem[s_ra];
	end

	always_ff @(posedge clk) begin
		if (b_we) begin
			b_mem[OCW'(out_channel)] <= data_value;
		end
		b_rd_q <= b_mem[OCW'(out_channel)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			oc_q             <= '0;
			t_q              <= '0;
			absent_q         <= 1'b0;
			ic_cnt_q         <= '0;
			tap_cnt_q        <= '0;
			off_q            <= '0;
			bias_load_q      <= 1'b0;
			v_s1_q           <= 1'b0;
			inrange_s1_q     <= 1'b0;
			out_valid_q      <= 1'b0;
			result_channel_q <= '0;
			result_time_q    <= '0;
			result_value_q   <= '0;
			saturated_q      <= 1'b0;
		end else begin
			bias_load_q  <= (state_q == ST_IDLE) && in_accept && (opcode == dce_pkg::OP_COMPUTE);
			v_s1_q       <= (state_q == ST_RUN);
			inrange_s1_q <= (state_q == ST_RUN) && pos_ok && !absent_q;
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept && (opcode == dce_pkg::OP_COMPUTE)) begin
						oc_q      <= out_channel;
						t_q       <= time_index;
						absent_q  <= (int'(out_channel) >= MAX_OUT_CH);
						ic_cnt_q  <= '0;
						tap_cnt_q <= '0;
						off_q     <= '0;
						state_q   <= ((nch == '0) || (ntap == '0)) ? ST_DRAIN : ST_RUN;
					end
				end
				ST_RUN: begin
					if (tap_cnt_q == ntap - dce_pkg::NTAP_W'(1)) begin
						tap_cnt_q <= '0;
						off_q     <= '0;
						if (ic_cnt_q == nch - dce_pkg::NCH_W'(1)) begin
							state_q <= ST_DRAIN;
						end else begin
							ic_cnt_q <= ic_cnt_q + dce_pkg::NCH_W'(1);
						end
					end else begin
						tap_cnt_q <= tap_cnt_q + dce_pkg::NTAP_W'(1);
						off_q     <= off_q + dce_pkg::OFF_W'(dilation_q);
					end
				end
				ST_DRAIN: begin
					if (res_load) begin
						result_channel_q <= oc_q;
						result_time_q    <= t_q;
						result_value_q   <= mac_value;
						saturated_q      <= mac_sat;
						state_q          <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign mac_ctl.load      = bias_load_q;
	assign mac_ctl.mul_valid = v_s1_q;
	assign mac_ctl.mul_en    = inrange_s1_q;
	assign mac_bias          = absent_q ? '0 : b_rd_q;

	dce_mac u_mac (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (mac_ctl),
		.bias         (mac_bias),
		.weight       (w_rd_s1),
		.sample       (s_rd_s1),
		.busy         (mac_busy),
		.result_value (mac_value),
		.saturated    (mac_sat)
	);

	assign out_valid      = out_valid_q;
	assign result_channel = result_channel_q;
	assign result_time    = result_time_q;
	assign result_value   = result_value_q;
	assign saturated      = saturated_q;

	// A new result appears only at the end of a compute item.
	a_result_from_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_DRAIN))
		else $error("result appeared outside the drain state");

	// The multiply pipeline holds work only while a compute item is in flight.
	a_pipe_in_compute: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1_q || mac_busy) |-> (state_q != ST_IDLE))
		else $error("multiply pipeline busy while idle");

	// Loading the bias must never collide with a product entering the accumulator.
	a_no_load_collision: assert property (@(posedge clk) disable iff (!arst_n)
		!(bias_load_q && mac_busy))
		else $error("bias load collided with an accumulate");

endmodule

// ----- tb/tb_dilated_conv1d_engine_top.sv -----
// Self-checking testbench for the dilated 1-D convolution engine: directed corner cases, then
// random shapes and items, with a scoreboard class that predicts every computed output.
// Depends on dce_pkg and dilated_conv1d_engine_top.
module tb_dilated_conv1d_engine_top;
	timeunit 1ns;
	timeprecision 1ps;

	import dce_pkg::*;

	localparam int CLK_PERIOD    = 10;
	localparam int CYCLE_LIMIT   = 3_000_000;
	localparam int ITEM_TARGET   = 400;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_CYCLES  = 64;
	localparam int STORE_CH      = 64;
	localparam int STORE_LEN     = 1024;
	localparam int STORE_TAPS    = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_PADDING + 1'b1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = '1;

	localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic signed [DATA_W-1:0] DATA_HALF_LSB = DATA_W'(1) <<< (FRAC_W - 1);

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RUNS} stall_mode_t;

	typedef struct packed {
		logic [OP_W-1:0]          op;
		logic [CH_W-1:0]          oc;
		logic [CH_W-1:0]          ic;
		logic [TAP_W-1:0]         tap;
		logic [TIME_W-1:0]        t;
		logic signed [DATA_W-1:0] value;
	} conv_item_t;

	typedef struct packed {
		logic [CH_W-1:0]          channel;
		logic [TIME_W-1:0]        t;
		logic signed [DATA_W-1:0] value;
		logic                     sat;
	} conv_result_t;

	class conv_scoreboard;
		logic signed [DATA_W-1:0] weights [0:65535];
		logic signed [DATA_W-1:0] biases [0:63];
		logic signed [DATA_W-1:0] samples [0:65535];
		int                       n_chan, seq_len, n_taps, dil, pad;
		conv_result_t             pending_outputs [$];
		int                       n_errors;

		function new();
			n_chan   = 1;
			seq_len  = 1024;
			n_taps   = 3;
			dil      = 1;
			pad      = 1;
			n_errors = 0;
		endfunction

		function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_IN_CHANNELS: n_chan  = data[NCH_W-1:0];
				CFG_SEQ_LENGTH:  seq_len = data[LEN_W-1:0];
				CFG_KERNEL_TAPS: n_taps  = data[NTAP_W-1:0];
				CFG_DILATION:    dil     = data[DIL_W-1:0];
				CFG_PADDING:     pad     = data[PAD_W-1:0];
				default: ;
			endcase
		endfunction

		function conv_result_t conv_output(conv_item_t it);
			int                       nch, len, ntap, i, j, pos;
			logic signed [ACC_W-1:0]  acc;
			longint                   s, r, hi, lo;
			conv_result_t             res;
			nch  = (n_chan > STORE_CH) ? STORE_CH : n_chan;
			len  = (seq_len > STORE_LEN) ? STORE_LEN : seq_len;
			ntap = (n_taps > STORE_TAPS) ? STORE_TAPS : n_taps;
			acc  = ACC_W'(longint'(biases[it.oc]) <<< FRAC_W);
			for (i = 0; i < nch; i++) begin
				for (j = 0; j < ntap; j++) begin
					pos = int'(it.t) + j * dil - pad;
					if (pos >= 0 && pos < len)
						acc += ACC_W'(longint'(weights[{it.oc, CH_W'(i), TAP_W'(j)}]) *
							longint'(samples[{CH_W'(i), TIME_W'(pos)}]));
				end
			end
			s  = acc;
			r  = (s + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
			hi = (longint'(1) <<< (DATA_W - 1)) - 1;
			lo = -hi - 1;
			res.sat = 1'b0;
			if (r > hi) begin
				r = hi;
				res.sat = 1'b1;
			end
			if (r < lo) begin
				r = lo;
				res.sat = 1'b1;
			end
			res.channel = it.oc;
			res.t       = it.t;
			res.value   = DATA_W'(r);
			return res;
		endfunction

		function void note_input(conv_item_t it);
			case (it.op)
				OP_WEIGHT: weights[{it.oc, it.ic, it.tap}] = it.value;
				OP_BIAS:   biases[it.oc] = it.value;
				OP_SAMPLE: samples[{it.ic, it.t}] = it.value;
				default:   pending_outputs.push_back(conv_output(it));
			endcase
		endfunction

		task report_mismatch(string what, longint got, longint want);
			$display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
			n_errors++;
		endtask

		task check_result(conv_result_t got);
			conv_result_t want;
			if (pending_outputs.size() == 0) begin
				report_mismatch("result with no request outstanding, time", got.t, -1);
			end else begin
				want = pending_outputs.pop_front();
				if (got.channel !== want.channel)
					report_mismatch("result_channel", got.channel, want.channel);
				if (got.t !== want.t)
					report_mismatch("result_time", got.t, want.t);
				if (got.value !== want.value)
					report_mismatch("result_value", $signed(got.value), $signed(want.value));
				if (got.sat !== want.sat)
					report_mismatch("saturated", got.sat, want.sat);
			end
		endtask

		task finish_check();
			if (pending_outputs.size() != 0)
				report_mismatch("results still outstanding", pending_outputs.size(), 0);
		endtask
	endclass

	logic                     clk            = 1'b0;
	logic                     arst_n         = 1'b0;
	logic                     in_valid       = 1'b0;
	logic                     in_stall;
	logic [OP_W-1:0]          opcode         = OP_WEIGHT;
	logic [CH_W-1:0]          out_channel    = '0;
	logic [CH_W-1:0]          in_channel     = '0;
	logic [TAP_W-1:0]         tap_index      = '0;
	logic [TIME_W-1:0]        time_index     = '0;
	logic signed [DATA_W-1:0] data_value     = '0;
	logic                     out_valid;
	logic                     out_stall      = 1'b0;
	logic [CH_W-1:0]          result_channel;
	logic [TIME_W-1:0]        result_time;
	logic signed [DATA_W-1:0] result_value;
	logic                     saturated;
	logic                     cfg_valid      = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_W-1:0]     cfg_index      = '0;
	logic [CFG_DATA_W-1:0]    cfg_data       = '0;

	conv_scoreboard sb = new();

	bit w_written [0:65535];
	bit s_written [0:65535];
	bit b_written [0:63];

	int shape_nch  = 1;
	int shape_len  = 1024;
	int shape_taps = 3;
	int shape_dil  = 1;
	int shape_pad  = 1;

	int          items_sent  = 0;
	int          burst_left  = 16;
	int          cycle_count = 0;
	stall_mode_t stall_mode  = STALL_NONE;
	int          stall_span  = 0;
	int          stall_hold  = 0;

	dilated_conv1d_engine_top i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.opcode         (opcode),
		.out_channel    (out_channel),
		.in_channel     (in_channel),
		.tap_index      (tap_index),
		.time_index     (time_index),
		.data_value     (data_value),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.result_channel (result_channel),
		.result_time    (result_time),
		.result_value   (result_value),
		.saturated      (saturated),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic logic signed [DATA_W-1:0] gen_value();
		case ($urandom_range(0, 4))
			0, 1: return DATA_W'($urandom);
			2, 3: return DATA_W'($urandom_range(0, 8191)) - DATA_W'(4096);
			default: begin
				case ($urandom_range(0, 6))
					0: return DATA_MAX;
					1: return DATA_MIN;
					2: return DATA_HALF_LSB;
					3: return -DATA_HALF_LSB;
					4: return DATA_W'(1);
					5: return -DATA_W'(1);
					default: return '0;
				endcase
			end
		endcase
	endfunction

	function automatic conv_item_t make_item(logic [OP_W-1:0] op, logic [CH_W-1:0] oc,
			logic [CH_W-1:0] ic, logic [TAP_W-1:0] tap, logic [TIME_W-1:0] t,
			logic signed [DATA_W-1:0] value);
		conv_item_t it;
		it.op    = op;
		it.oc    = oc;
		it.ic    = ic;
		it.tap   = tap;
		it.t     = t;
		it.value = value;
		return it;
	endfunction

	task automatic send_raw(conv_item_t it);
		in_valid    <= 1'b1;
		opcode      <= it.op;
		out_channel <= it.oc;
		in_channel  <= it.ic;
		tap_index   <= it.tap;
		time_index  <= it.t;
		data_value  <= it.value;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_input(it);
		items_sent++;
		case (it.op)
			OP_WEIGHT: w_written[{it.oc, it.ic, it.tap}] = 1'b1;
			OP_BIAS:   b_written[it.oc] = 1'b1;
			OP_SAMPLE: s_written[{it.ic, it.t}] = 1'b1;
			default: ;
		endcase
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8))
				@(posedge clk);
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) :
				$urandom_range(1, 24);
		end
	endtask

	// Every entry a compute item will read is written first, with random content.
	task automatic prepare_reads(logic [CH_W-1:0] oc, logic [TIME_W-1:0] t);
		int i, j, pos;
		if (!b_written[oc])
			send_raw(make_item(OP_BIAS, oc, CH_W'($urandom), TAP_W'($urandom),
				TIME_W'($urandom), gen_value()));
		for (i = 0; i < shape_nch; i++) begin
			for (j = 0; j < shape_taps; j++) begin
				if (!w_written[{oc, CH_W'(i), TAP_W'(j)}])
					send_raw(make_item(OP_WEIGHT, oc, CH_W'(i), TAP_W'(j),
						TIME_W'($urandom), gen_value()));
				pos = int'(t) + j * shape_dil - shape_pad;
				if (pos >= 0 && pos < shape_len && !s_written[{CH_W'(i), TIME_W'(pos)}])
					send_raw(make_item(OP_SAMPLE, CH_W'($urandom), CH_W'(i),
						TAP_W'($urandom), TIME_W'(pos), gen_value()));
			end
		end
	endtask

	task automatic issue(conv_item_t it);
		if (it.op == OP_COMPUTE)
			prepare_reads(it.oc, it.t);
		send_raw(it);
	endtask

	task automatic put(logic [OP_W-1:0] op, logic [CH_W-1:0] oc, logic [CH_W-1:0] ic,
			logic [TAP_W-1:0] tap, logic [TIME_W-1:0] t, logic signed [DATA_W-1:0] value);
		issue(make_item(op, oc, ic, tap, t, value));
	endtask

	task automatic quiesce();
		if (in_valid) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		while (sb.pending_outputs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.note_config(idx, data);
	endtask

	task automatic apply_shape(logic [CFG_DATA_W-1:0] nch, logic [CFG_DATA_W-1:0] len,
			logic [CFG_DATA_W-1:0] taps, logic [CFG_DATA_W-1:0] dil,
			logic [CFG_DATA_W-1:0] pad);
		quiesce();
		write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)),
			CFG_DATA_W'($urandom));
		write_reg(CFG_IN_CHANNELS, nch);
		write_reg(CFG_SEQ_LENGTH, len);
		write_reg(CFG_KERNEL_TAPS, taps);
		write_reg(CFG_DILATION, dil);
		write_reg(CFG_PADDING, pad);
		cfg_valid  <= 1'b0;
		shape_nch  = (nch[NCH_W-1:0] > STORE_CH) ? STORE_CH : nch[NCH_W-1:0];
		shape_len  = (len[LEN_W-1:0] > STORE_LEN) ? STORE_LEN : len[LEN_W-1:0];
		shape_taps = (taps[NTAP_W-1:0] > STORE_TAPS) ? STORE_TAPS : taps[NTAP_W-1:0];
		shape_dil  = dil[DIL_W-1:0];
		shape_pad  = pad[PAD_W-1:0];
	endtask

	task automatic run_random_phase(int n_items);
		logic [CH_W-1:0] chans [3];
		conv_item_t      it;
		int              k, r, reach;
		foreach (chans[c])
			chans[c] = CH_W'($urandom);
		reach = shape_len + shape_pad;
		if (reach > STORE_LEN - 1)
			reach = STORE_LEN - 1;
		for (k = 0; k < n_items; k++) begin
			it = make_item(OP_WEIGHT, CH_W'($urandom), CH_W'($urandom), TAP_W'($urandom),
				TIME_W'($urandom), gen_value());
			r = $urandom_range(0, 99);
			if (r < 40) begin
				it.op = OP_COMPUTE;
				if ($urandom_range(0, 9) != 0)
					it.oc = chans[$urandom_range(0, 2)];
				if ($urandom_range(0, 1) != 0)
					it.t = TIME_W'($urandom_range(0, reach));
			end else if (r < 60) begin
				it.oc = chans[$urandom_range(0, 2)];
				if (shape_nch > 0)
					it.ic = CH_W'($urandom_range(0, shape_nch - 1));
				if (shape_taps > 0)
					it.tap = TAP_W'($urandom_range(0, shape_taps - 1));
			end else if (r < 75) begin
				it.op = OP_SAMPLE;
				if (shape_nch > 0)
					it.ic = CH_W'($urandom_range(0, shape_nch - 1));
				if (shape_len > 0)
					it.t = TIME_W'($urandom_range(0, shape_len - 1));
			end else if (r < 82) begin
				it.op = OP_BIAS;
				it.oc = chans[$urandom_range(0, 2)];
			end else begin
				it.op = OP_W'($urandom_range(OP_WEIGHT, OP_SAMPLE));
			end
			issue(it);
		end
	endtask

	always @(posedge clk) begin : result_sink
		logic stall_next;
		if (arst_n && out_valid && !out_stall)
			sb.check_result('{result_channel, result_time, result_value, saturated});
		if (stall_span == 0) begin
			stall_mode = stall_mode_t'($urandom_range(STALL_NONE, STALL_RUNS));
			stall_span = $urandom_range(16, 256);
		end
		stall_span--;
		case (stall_mode)
			STALL_NONE:  stall_next = 1'b0;
			STALL_LIGHT: stall_next = ($urandom_range(0, 3) == 0);
			STALL_HEAVY: stall_next = ($urandom_range(0, 3) != 0);
			default: begin
				if (stall_hold == 0) begin
					stall_next = !out_stall;
					stall_hold = $urandom_range(1, 20);
				end else begin
					stall_next = out_stall;
					stall_hold--;
				end
			end
		endcase
		out_stall <= stall_next;
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : stimulus
		int p, j, mode, n_items;
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		put(OP_COMPUTE, 0, 0, 0, 0, 0);
		put(OP_BIAS, 63, 0, 0, 0, DATA_MAX);
		for (j = 0; j < 3; j++)
			put(OP_WEIGHT, 63, 0, j, 0, DATA_MAX);
		for (p = 1021; p <= 1023; p++)
			put(OP_SAMPLE, 0, 0, 0, p, DATA_MAX);
		put(OP_COMPUTE, 63, 0, 0, 1022, 0);
		for (p = 1021; p <= 1023; p++)
			put(OP_SAMPLE, 0, 0, 0, p, DATA_MIN);
		put(OP_COMPUTE, 63, 0, 0, 1022, 0);
		put(OP_COMPUTE, 63, 0, 0, 1023, 0);

		// A product of exactly half an LSB must round upwards, and minus half to zero.
		put(OP_BIAS, 7, 0, 0, 0, 0);
		put(OP_WEIGHT, 7, 0, 0, 0, 0);
		put(OP_WEIGHT, 7, 0, 1, 0, DATA_W'(1));
		put(OP_WEIGHT, 7, 0, 2, 0, 0);
		put(OP_SAMPLE, 0, 0, 0, 10, DATA_HALF_LSB);
		put(OP_COMPUTE, 7, 0, 0, 10, 0);
		put(OP_SAMPLE, 0, 0, 0, 10, -DATA_HALF_LSB);
		put(OP_COMPUTE, 7, 0, 0, 10, 0);

		apply_shape(0, 1024, 3, 1, 1);
		put(OP_COMPUTE, 63, 0, 0, 5, 0);
		put(OP_BIAS, 63, 0, 0, 0, DATA_MIN);
		put(OP_COMPUTE, 63, 0, 0, 5, 0);
		// Oversized channel count with a single tap, then oversized tap count on one channel.
		apply_shape('1, '1, 1, '1, '1);
		put(OP_COMPUTE, 63, 0, 0, 1023, 0);
		apply_shape(1, '1, '1, '1, '1);
		put(OP_COMPUTE, 63, 63, 15, 1023, 0);
		put(OP_COMPUTE, 63, 0, 0, 0, 0);
		apply_shape(2, 1024, 16, 0, 0);
		put(OP_COMPUTE, 1, 0, 0, 1023, 0);
		apply_shape(1, 0, 0, 1, 0);
		put(OP_COMPUTE, 2, 0, 0, 0, 0);

		while (items_sent < ITEM_TARGET) begin
			mode = $urandom_range(0, 9);
			if (mode < 7) begin
				apply_shape($urandom_range(1, 4),
					($urandom_range(0, 3) == 0) ? STORE_LEN : $urandom_range(1, 64),
					$urandom_range(1, 5), $urandom_range(0, 4), $urandom_range(0, 8));
				n_items = 40;
			end else if (mode < 9) begin
				apply_shape($urandom_range(1, 8), $urandom_range(1, 1024),
					$urandom_range(1, 8), $urandom_range(0, 64), $urandom_range(0, 512));
				n_items = 16;
			end else begin
				apply_shape($urandom_range(0, 3), $urandom_range(0, 2047),
					$urandom_range(0, 3), $urandom_range(0, 127), $urandom_range(0, 1023));
				n_items = 6;
			end
			run_random_phase(n_items);
		end

		if (in_valid) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		while (sb.pending_outputs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		sb.finish_check();
		if (sb.n_errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
